### rtl/core/c8fc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8fc_pkg
// Shared constants, types and the CRC-8 byte step for the frame checker.
// ----------------------------------------------------------------------------
package c8fc_pkg;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] FRAME_END = 8'h0A;

    localparam int unsigned MAX_FRAME = 128;
    localparam int unsigned LIM_W     = $clog2(MAX_FRAME + 1);

    localparam logic [7:0] LIMIT_RST = 8'd128;
    localparam logic [7:0] ACK_RST   = 8'd6;
    localparam logic [7:0] NAK_RST   = 8'd21;

    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_ACK   = 2'd1;
    localparam logic [1:0] REG_NAK   = 2'd2;

    localparam logic [1:0] BEAT_CODE = 2'd0;
    localparam logic [1:0] BEAT_CRC  = 2'd1;
    localparam logic [1:0] BEAT_END  = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [6:0] len;
    } frame_stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    localparam logic [7:0] ACK_CRC_RST = crc8_byte(8'h00, ACK_RST);
    localparam logic [7:0] NAK_CRC_RST = crc8_byte(8'h00, NAK_RST);

endpackage
`default_nettype wire

### rtl/core/c8fc_frame_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c8fc_frame_track
// Running CRC, byte count and overflow state of the frame being received;
// gives the verdict and payload length for the frame ended by a terminator.
// ----------------------------------------------------------------------------
module c8fc_frame_track
    import c8fc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        word_fire,
    input  wire logic [7:0]  word_byte,
    input  wire logic [7:0]  frame_limit,
    output frame_stat_t      stat
);

    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       prior_reg, prior_next;
    logic [7:0]       newest_reg, newest_next;
    logic [7:0]       count_reg, count_next;
    logic             long_reg, long_next;
    logic [LIM_W-1:0] lim;
    logic [7:0]       count_inc;

    always_comb begin
        if ({{(LIM_W > 8 ? LIM_W - 8 : 1){1'b0}}, frame_limit} > (LIM_W + 1)'(MAX_FRAME)) begin
            lim = LIM_W'(MAX_FRAME);
        end else begin
            lim = LIM_W'(frame_limit);
        end
    end

    assign count_inc = (count_reg == 8'hFF) ? count_reg : count_reg + 8'd1;

    always_comb begin
        crc_next    = crc_reg;
        prior_next  = prior_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        long_next   = long_reg;
        if (word_fire) begin
            if (word_byte == FRAME_END) begin
                crc_next    = '0;
                prior_next  = '0;
                newest_next = '0;
                count_next  = '0;
                long_next   = 1'b0;
            end else begin
                prior_next  = crc_reg;
                crc_next    = crc8_byte(crc_reg, word_byte);
                newest_next = word_byte;
                count_next  = count_inc;
                long_next   = long_reg | ({1'b0, count_inc} >= {1'b0, 8'(lim)});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= '0;
            prior_reg  <= '0;
            newest_reg <= '0;
            count_reg  <= '0;
            long_reg   <= 1'b0;
        end else begin
            crc_reg    <= crc_next;
            prior_reg  <= prior_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            long_reg   <= long_next;
        end
    end

    always_comb begin
        stat.ok  = !long_reg && ({1'b0, count_reg} < {1'b0, 8'(lim)})
                   && (count_reg != 8'd0) && (prior_reg == newest_reg);
        stat.len = stat.ok ? 7'(count_reg - 8'd1) : 7'd0;
    end

endmodule
`default_nettype wire

### rtl/core/crc8_frame_checker_ack_nak_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_frame_checker_ack_nak_top
// Checks CRC-8 framed receive bytes and replies with ACK or NAK.
//
// Input channel s_*: one received byte per word. A frame is payload bytes,
// a CRC-8 byte (poly 0x07, init 0) and the terminator 0x0A. Each byte is
// folded into the frame state in the cycle it is taken, one byte per cycle.
// Result channel m_*: three words per terminator - the ACK/NAK code, the
// CRC-8 of that code, then 0x0A with m_reply_last set. m_frame_ok and
// m_payload_len hold for all three words.
// Latency: the first reply word is valid the cycle after the terminator is
// taken; the reply then moves one word per cycle while m_ready is high.
// Throughput: one byte per cycle; a terminator is held off only while the
// previous reply still has words to send beyond the one leaving now, so a
// terminator every three bytes runs at full rate while m_ready stays high.
// A stalled receiver holds the reply; non-terminator bytes keep flowing.
// Reset (aresetn low, synchronous) clears the frame state, drops any reply
// and restores frame_limit 128, ack_code 6, nak_code 21.
// Registers over APB: 0x0 frame_limit, 0x4 ack_code, 0x8 nak_code.
// ----------------------------------------------------------------------------
module crc8_frame_checker_ack_nak_top
    import c8fc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_tx_byte,
    output logic             m_reply_last,
    output logic             m_frame_ok,
    output logic [6:0]       m_payload_len,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  limit_reg;
    logic [7:0]  ack_reg;
    logic [7:0]  nak_reg;
    logic [7:0]  ack_crc_reg;
    logic [7:0]  nak_crc_reg;
    logic        cfg_wr;

    logic        busy_reg, busy_next;
    logic [1:0]  beat_reg, beat_next;
    logic        ok_reg, ok_next;
    logic [6:0]  len_reg, len_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  ccrc_reg, ccrc_next;

    logic        s_fire;
    logic        m_fire;
    logic        term_fire;
    frame_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RST;
            ack_reg     <= ACK_RST;
            nak_reg     <= NAK_RST;
            ack_crc_reg <= ACK_CRC_RST;
            nak_crc_reg <= NAK_CRC_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LIMIT: begin
                    limit_reg <= pwdata[7:0];
                end
                REG_ACK: begin
                    ack_reg     <= pwdata[7:0];
                    ack_crc_reg <= crc8_byte(8'h00, pwdata[7:0]);
                end
                REG_NAK: begin
                    nak_reg     <= pwdata[7:0];
                    nak_crc_reg <= crc8_byte(8'h00, pwdata[7:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LIMIT: prdata = {24'd0, limit_reg};
            REG_ACK:   prdata = {24'd0, ack_reg};
            REG_NAK:   prdata = {24'd0, nak_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign m_valid   = busy_reg;
    assign m_fire    = m_valid && m_ready;
    assign s_ready   = !busy_reg || (s_rx_byte != FRAME_END)
                       || (m_ready && beat_reg == BEAT_END);
    assign s_fire    = s_valid && s_ready;
    assign term_fire = s_fire && (s_rx_byte == FRAME_END);

    c8fc_frame_track u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .word_fire   (s_fire),
        .word_byte   (s_rx_byte),
        .frame_limit (limit_reg),
        .stat        (stat)
    );

    always_comb begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        ok_next   = ok_reg;
        len_next  = len_reg;
        code_next = code_reg;
        ccrc_next = ccrc_reg;
        if (m_fire) begin
            if (beat_reg == BEAT_END) begin
                busy_next = 1'b0;
            end else begin
                beat_next = beat_reg + 2'd1;
            end
        end
        if (term_fire) begin
            busy_next = 1'b1;
            beat_next = BEAT_CODE;
            ok_next   = stat.ok;
            len_next  = stat.len;
            code_next = stat.ok ? ack_reg : nak_reg;
            ccrc_next = stat.ok ? ack_crc_reg : nak_crc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_CODE;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg   <= ok_next;
        len_reg  <= len_next;
        code_reg <= code_next;
        ccrc_reg <= ccrc_next;
    end

    always_comb begin
        unique case (beat_reg)
            BEAT_CODE: m_tx_byte = code_reg;
            BEAT_CRC:  m_tx_byte = ccrc_reg;
            default:   m_tx_byte = FRAME_END;
        endcase
    end

    assign m_reply_last  = (beat_reg == BEAT_END);
    assign m_frame_ok    = ok_reg;
    assign m_payload_len = len_reg;

`ifndef SYNTH
    a_beat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (beat_reg == BEAT_CODE || beat_reg == BEAT_CRC || beat_reg == BEAT_END))
        else $error("reply beat out of range");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reply_last) |-> (m_tx_byte == FRAME_END))
        else $error("last reply word is not the terminator");

    a_term_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        term_fire |=> (m_valid && beat_reg == BEAT_CODE))
        else $error("terminator did not start a reply");

    a_nak_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_ok) |-> (m_payload_len == 7'd0))
        else $error("rejected frame reports a length");
`endif

endmodule
`default_nettype wire
